### rtl/core/cbirp_pkg.sv
`timescale 1ns / 1ps

package cbirp_pkg;

	// stream widths
	localparam int S_TDATA_W = 32;   // address, write_data, tick_cycles
	localparam int S_TUSER_W = 3;    // command
	localparam int M_TDATA_W = 24;   // read_data, read_claimed, irq_line, map_bank, pad
	localparam int M_TUSER_W = 1;    // map_source
	localparam int CFG_IDX_W = 2;

	localparam int RAM_DEPTH_DEF = 128;

	typedef enum logic [2:0] {
		CMD_CPU_WRITE  = 3'd0,
		CMD_CPU_READ   = 3'd1,
		CMD_TICK       = 3'd2,
		CMD_PPU_LOOKUP = 3'd3,
		CMD_CPU_LOOKUP = 3'd4
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIRRORING = 2'd0,
		CFG_CHR_MASK  = 2'd1,
		CFG_PRG_MASK  = 2'd2
	} cfg_idx_t;

	// 2 KB pages of the cpu bus, address[15:11]
	localparam logic [4:0] PG_RAM_DATA = 5'd9;    // 0x4800
	localparam logic [4:0] PG_IRQ_LO   = 5'd10;   // 0x5000
	localparam logic [4:0] PG_IRQ_HI   = 5'd11;   // 0x5800
	localparam logic [4:0] PG_CHR_LO   = 5'd16;   // 0x8000
	localparam logic [4:0] PG_CHR_HI   = 5'd23;   // 0xB800
	localparam logic [4:0] PG_NT_LO    = 5'd24;   // 0xC000
	localparam logic [4:0] PG_NT_HI    = 5'd27;   // 0xD800
	localparam logic [4:0] PG_PRG0     = 5'd28;   // 0xE000
	localparam logic [4:0] PG_PRG1     = 5'd29;   // 0xE800
	localparam logic [4:0] PG_PRG2     = 5'd30;   // 0xF000
	localparam logic [4:0] PG_PTR      = 5'd31;   // 0xF800

	localparam logic [7:0]  CIRAM_BASE = 8'hE0;
	localparam logic [14:0] IRQ_MAX    = 15'h7FFF;
	localparam logic [7:0]  FIXED_PRG  = 8'hFF;

	typedef struct packed {
		logic [7:0] rdata;
		logic       claimed;
		logic       irq;
		logic       src;
		logic [7:0] bank;
	} res_t;

	// nametable reset arrangement: slot 0 E0, slot 3 E1, middle pair by mode
	function automatic logic [7:0] nt_init(input logic mode, input logic [1:0] slot);
		logic sel;
		sel = mode ? slot[0] : slot[1];
		return CIRAM_BASE | {7'd0, sel};
	endfunction

endpackage

### rtl/core/cbirp_ram.sv
`timescale 1ns / 1ps

module cbirp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/cartridge_bank_irq_ram_port.sv
`timescale 1ns / 1ps

// Cartridge bank / IRQ / internal RAM controller. One item per clock on the
// input stream while the output is not stalled. The 128-byte RAM has a
// registered read port in stage 1, then the result sits in an output
// register. All bank, pointer and counter state is updated in the cycle the
// item is accepted, so the next item sees it without a bubble; RAM writes
// land at the accept edge and a read issued on the following item already
// sees them. RAM contents read as zero until written (per-entry valid bits,
// cleared by reset), so no clearing pass is needed after reset. Input item:
// s_tuser carries the command, s_tdata the address, write byte and tick
// count. Result item: m_tuser is map_source, m_tdata the rest. Config writes
// (mirroring mode, CHR mask, PRG mask) are always accepted and are meant to
// be issued while the block is idle; a mirroring write reloads the
// nametable banks.

module cartridge_bank_irq_ram_port #(
	parameter int RAM_DEPTH = cbirp_pkg::RAM_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input items
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [cbirp_pkg::S_TDATA_W-1:0] s_tdata,   // address[15:0], write_data[7:0], tick_cycles[7:0]
	input  logic [cbirp_pkg::S_TUSER_W-1:0] s_tuser,   // command[2:0]
	// result items
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cbirp_pkg::M_TDATA_W-1:0] m_tdata,   // read_data[7:0], read_claimed, irq_line, map_bank[7:0], zero[5:0]
	output logic [cbirp_pkg::M_TUSER_W-1:0] m_tuser,   // map_source
	// config writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cbirp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_data
);

	import cbirp_pkg::*;

	localparam int RAM_AW = $clog2(RAM_DEPTH);

	// input fields
	logic        in_acc;
	cmd_t        cmd;
	logic [15:0] addr;
	logic [7:0]  wdata;
	logic [7:0]  cycles;
	logic [4:0]  page;

	// config registers
	logic [7:0] chr_mask_q;
	logic [7:0] prg_mask_q;
	logic       cfg_wr;
	logic       nt_reload;

	// mapper state
	logic [7:0]  pat_q [8];
	logic [7:0]  nt_q  [4];
	logic [7:0]  prg_q [3];
	logic [1:0]  prd_q;
	logic [7:0]  ptr_q;
	logic [14:0] cnt_q;
	logic        en_q;
	logic        pend_q;

	logic [7:0]  pat_d [8];
	logic [7:0]  nt_d  [4];
	logic [7:0]  prg_d [3];
	logic [1:0]  prd_d;
	logic [7:0]  ptr_d;
	logic [14:0] cnt_d;
	logic        en_d;
	logic        pend_d;

	logic [15:0] tick_sum;
	logic [7:0]  ptr_bump;
	logic [2:0]  pat_slot;
	logic [7:0]  lk_val;
	logic        lk_dis;

	// RAM port
	logic              ram_we;
	logic              ram_re;
	logic [RAM_AW-1:0] ram_idx;
	logic [7:0]        ram_rdata;
	logic [RAM_DEPTH-1:0] ram_vld_q;

	// stage 1 and output register
	res_t res_d;
	res_t res_s1;
	logic s1_vld_s1;
	logic ram_sel_s1;
	logic ram_ok_s1;
	logic s1_adv;
	logic out_vld_q;
	res_t out_d;
	res_t out_q;

	assign in_acc = s_tvalid && s_tready;
	assign cmd    = cmd_t'(s_tuser);
	assign addr   = s_tdata[15:0];
	assign wdata  = s_tdata[23:16];
	assign cycles = s_tdata[31:24];
	assign page   = addr[15:11];

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid;
	assign nt_reload = cfg_wr && (cfg_idx_t'(cfg_index) == CFG_MIRRORING);

	assign ram_idx  = ptr_q[RAM_AW-1:0];
	assign ptr_bump = ptr_q[7] ? {1'b1, ptr_q[6:0] + 7'd1} : ptr_q;
	assign tick_sum = {1'b0, cnt_q} + {8'd0, cycles};
	assign pat_slot = addr[12:10];

	// lookup source value and disable bit
	always_comb begin
		if (!addr[13]) begin
			lk_val = pat_q[pat_slot];
			lk_dis = prd_q[pat_slot[2]];
		end else begin
			lk_val = nt_q[addr[11:10]];
			lk_dis = 1'b0;
		end
	end

	// next state and result for the accepted item
	always_comb begin
		pat_d  = pat_q;
		nt_d   = nt_q;
		prg_d  = prg_q;
		prd_d  = prd_q;
		ptr_d  = ptr_q;
		cnt_d  = cnt_q;
		en_d   = en_q;
		pend_d = pend_q;
		ram_we = 1'b0;
		ram_re = 1'b0;
		res_d  = '0;
		// mirroring write reloads the nametable arrangement
		if (nt_reload) begin
			for (int i = 0; i < 4; i++) nt_d[i] = nt_init(cfg_data[0], 2'(i));
		end
		if (in_acc) begin
			case (cmd)
				CMD_CPU_WRITE: begin
					case (page) inside
						[PG_CHR_LO:PG_CHR_HI]: pat_d[page[2:0]] = wdata;
						[PG_NT_LO:PG_NT_HI]:   nt_d[page[1:0]]  = wdata;
						PG_RAM_DATA: begin
							ram_we = 1'b1;
							ptr_d  = ptr_bump;
						end
						PG_PTR: ptr_d = wdata;
						PG_IRQ_LO: begin
							cnt_d  = {cnt_q[14:8], wdata};
							pend_d = 1'b0;
						end
						PG_IRQ_HI: begin
							cnt_d  = {wdata[6:0], cnt_q[7:0]};
							en_d   = wdata[7];
							pend_d = 1'b0;
						end
						PG_PRG0: prg_d[0] = wdata;
						PG_PRG1: begin
							prg_d[1] = wdata;
							prd_d    = wdata[7:6];
						end
						PG_PRG2: prg_d[2] = wdata;
						default: ;
					endcase
				end
				CMD_CPU_READ: begin
					case (page)
						PG_RAM_DATA: begin
							ram_re        = 1'b1;
							ptr_d         = ptr_bump;
							res_d.claimed = 1'b1;
						end
						PG_IRQ_LO: begin
							res_d.rdata   = cnt_q[7:0];
							res_d.claimed = 1'b1;
						end
						PG_IRQ_HI: begin
							res_d.rdata   = {1'b0, cnt_q[14:8]};
							res_d.claimed = 1'b1;
						end
						default: ;
					endcase
				end
				CMD_TICK: begin
					if (en_q) begin
						if (tick_sum >= {1'b0, IRQ_MAX}) begin
							cnt_d  = IRQ_MAX;
							en_d   = 1'b0;
							pend_d = 1'b1;
						end else begin
							cnt_d = tick_sum[14:0];
						end
					end
				end
				CMD_PPU_LOOKUP: begin
					if (!lk_dis && lk_val >= CIRAM_BASE) begin
						res_d.src  = 1'b1;
						// pattern slots use 8 pages of RAM, nametables 2
						res_d.bank = addr[13] ? {7'd0, lk_val[0]} : {5'd0, lk_val[2:0]};
					end else begin
						res_d.bank = lk_val & chr_mask_q;
					end
				end
				CMD_CPU_LOOKUP: begin
					if (addr[15:13] == 3'b111) begin
						res_d.bank = FIXED_PRG & prg_mask_q;
					end else if (addr[15]) begin
						res_d.bank = prg_q[addr[14:13]] & prg_mask_q;
					end
				end
				default: ;
			endcase
			res_d.irq = pend_d;
		end
	end

	// config and mapper registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chr_mask_q <= 8'hFF;
			prg_mask_q <= 8'hFF;
			for (int i = 0; i < 8; i++) pat_q[i] <= '0;
			for (int i = 0; i < 4; i++) nt_q[i] <= nt_init(1'b0, 2'(i));
			for (int i = 0; i < 3; i++) prg_q[i] <= '0;
			prd_q  <= 2'b11;
			ptr_q  <= '0;
			cnt_q  <= '0;
			en_q   <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			pat_q  <= pat_d;
			prg_q  <= prg_d;
			prd_q  <= prd_d;
			ptr_q  <= ptr_d;
			cnt_q  <= cnt_d;
			en_q   <= en_d;
			pend_q <= pend_d;
			nt_q   <= nt_d;
			if (cfg_wr) begin
				case (cfg_idx_t'(cfg_index))
					CFG_MIRRORING: ;   // only reloads the nametables, see next-state logic
					CFG_CHR_MASK: chr_mask_q <= cfg_data;
					CFG_PRG_MASK: prg_mask_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// internal RAM; entries never written read as zero
	cbirp_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_idx),
		.wdata (wdata),
		.re    (ram_re),
		.raddr (ram_idx),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_vld_q <= '0;
		end else if (ram_we) begin
			ram_vld_q[ram_idx] <= 1'b1;
		end
	end

	// stage 1: RAM read in flight; RAM output holds while stage 1 is stalled
	assign s1_adv   = !out_vld_q || m_tready;
	assign s_tready = !s1_vld_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_s1 <= 1'b0;
		end else if (s_tready) begin
			s1_vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_s1     <= res_d;
			ram_sel_s1 <= ram_re;
			ram_ok_s1  <= ram_vld_q[ram_idx];
		end
	end

	// RAM data merged into the stage 1 result
	always_comb begin
		out_d = res_s1;
		if (ram_sel_s1) begin
			out_d.rdata = ram_ok_s1 ? ram_rdata : 8'd0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_adv) begin
			out_vld_q <= s1_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_vld_s1) begin
			out_q <= out_d;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'd0, out_q.bank, out_q.irq, out_q.claimed, out_q.rdata};
	assign m_tuser  = out_q.src;

endmodule

### rtl/core/cbirp_check.sv
`timescale 1ns / 1ps

module cbirp_check (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [cbirp_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [cbirp_pkg::M_TUSER_W-1:0] m_tuser
);

	import cbirp_pkg::*;

	// stalled item stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result item dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result item changed while stalled");

	// a RAM-side lookup names a bank inside the 8 KB of cartridge RAM
	a_ram_bank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[17:13] == 5'd0 && m_tdata[8] == 1'b0)
		else $error("ram lookup with wide bank or claimed read");

	// unclaimed reads return zero
	a_unclaimed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[8] |-> m_tdata[7:0] == 8'd0)
		else $error("data on unclaimed item");

endmodule

bind cartridge_bank_irq_ram_port cbirp_check u_cbirp_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

### dv/mapper_result_checker.sv
`timescale 1ns / 1ps

module mapper_result_checker
	import cbirp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // address[15:0], write_data[7:0], tick_cycles[7:0]
	input  logic [S_TUSER_W-1:0] s_tuser,   // command[2:0]
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,   // read_data[7:0], claimed, irq, map_bank[7:0], zero[5:0]
	input  logic [M_TUSER_W-1:0] m_tuser,   // map_source
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output int                   mismatches,
	output int                   pending,
	output int                   results_checked,
	output int                   irq_raises
);

	// mapper state as this side tracks it
	logic        mirror_vert;
	logic [7:0]  chr_mask;
	logic [7:0]  prg_mask;
	logic [7:0]  chr_bank [8];
	logic [7:0]  nt_bank [4];
	logic [7:0]  prg_bank [3];
	logic [1:0]  chr_ram_off;
	logic [7:0]  ram_ptr;
	logic [7:0]  ext_ram [RAM_DEPTH_DEF];
	logic [14:0] irq_count;
	logic        irq_on;
	logic        irq_flag;

	res_t due_results [$];
	res_t want;
	res_t next_due;

	task automatic load_nametables();
		nt_bank[0] = CIRAM_BASE;
		nt_bank[1] = mirror_vert ? (CIRAM_BASE | 8'd1) : CIRAM_BASE;
		nt_bank[2] = mirror_vert ? CIRAM_BASE : (CIRAM_BASE | 8'd1);
		nt_bank[3] = CIRAM_BASE | 8'd1;
	endtask

	// pointer bit 7 turns on auto-increment of the low seven bits
	task automatic advance_ptr();
		if (ram_ptr[7])
			ram_ptr[6:0] = ram_ptr[6:0] + 7'd1;
	endtask

	task automatic bus_write(input logic [15:0] a, input logic [7:0] d);
		logic [4:0] pg;
		pg = a[15:11];
		if (pg >= PG_CHR_LO && pg <= PG_CHR_HI) begin
			chr_bank[pg[2:0]] = d;
		end else if (pg >= PG_NT_LO && pg <= PG_NT_HI) begin
			nt_bank[pg[1:0]] = d;
		end else begin
			case (pg)
				PG_RAM_DATA: begin
					ext_ram[ram_ptr[6:0]] = d;
					advance_ptr();
				end
				PG_PTR: ram_ptr = d;
				PG_IRQ_LO: begin
					irq_count[7:0] = d;
					irq_flag = 1'b0;
				end
				PG_IRQ_HI: begin
					irq_count[14:8] = d[6:0];
					irq_on = d[7];
					irq_flag = 1'b0;
				end
				PG_PRG0: prg_bank[0] = d;
				PG_PRG1: begin
					chr_ram_off = d[7:6];
					prg_bank[1] = d;
				end
				PG_PRG2: prg_bank[2] = d;
				default: ;
			endcase
		end
	endtask

	// one bus item in, one result out; updates the tracked state
	task automatic apply_bus_item(input cmd_t cmd, input logic [15:0] a, input logic [7:0] d,
			input logic [7:0] ticks, output res_t r);
		logic [15:0] sum;
		logic [7:0]  v;
		logic [2:0]  slot;
		r = '0;
		case (cmd)
			CMD_CPU_WRITE: bus_write(a, d);
			CMD_CPU_READ: begin
				case (a[15:11])
					PG_RAM_DATA: begin
						r.rdata = ext_ram[ram_ptr[6:0]];
						r.claimed = 1'b1;
						advance_ptr();
					end
					PG_IRQ_LO: begin
						r.rdata = irq_count[7:0];
						r.claimed = 1'b1;
					end
					PG_IRQ_HI: begin
						r.rdata = {1'b0, irq_count[14:8]};
						r.claimed = 1'b1;
					end
					default: ;
				endcase
			end
			CMD_TICK: begin
				if (irq_on) begin
					sum = {1'b0, irq_count} + {8'd0, ticks};
					if (sum >= {1'b0, IRQ_MAX}) begin
						irq_count = IRQ_MAX;
						irq_flag = 1'b1;
						irq_on = 1'b0;
						irq_raises++;
					end else begin
						irq_count = sum[14:0];
					end
				end
			end
			CMD_PPU_LOOKUP: begin
				// ppu bus is 14 bits wide, upper address bits ignored
				if (!a[13]) begin
					slot = a[12:10];
					v = chr_bank[slot];
					if (!chr_ram_off[slot[2]] && v >= CIRAM_BASE) begin
						r.src = 1'b1;
						r.bank = {5'd0, v[2:0]};
					end else begin
						r.bank = v & chr_mask;
					end
				end else begin
					v = nt_bank[a[11:10]];
					if (v >= CIRAM_BASE) begin
						r.src = 1'b1;
						r.bank = {7'd0, v[0]};
					end else begin
						r.bank = v & chr_mask;
					end
				end
			end
			CMD_CPU_LOOKUP: begin
				if (a[15:11] >= PG_PRG0)
					r.bank = FIXED_PRG & prg_mask;
				else if (a[15:11] >= PG_CHR_LO)
					r.bank = prg_bank[a[14:13]] & prg_mask;
			end
			default: ;
		endcase
		r.irq = irq_flag;
	endtask

	function automatic void flag_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, exp_v, got_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_vert = 1'b0;
			chr_mask = 8'hFF;
			prg_mask = 8'hFF;
			for (int i = 0; i < 8; i++)
				chr_bank[i] = 8'd0;
			for (int i = 0; i < 3; i++)
				prg_bank[i] = 8'd0;
			for (int i = 0; i < RAM_DEPTH_DEF; i++)
				ext_ram[i] = 8'd0;
			load_nametables();
			chr_ram_off = 2'b11;
			ram_ptr = 8'd0;
			irq_count = 15'd0;
			irq_on = 1'b0;
			irq_flag = 1'b0;
			due_results.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result item, expected none, got tdata %h tuser %h",
						$time, m_tdata, m_tuser);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					results_checked++;
					flag_field("read_data", want.rdata, m_tdata[7:0]);
					flag_field("read_claimed", {7'd0, want.claimed}, {7'd0, m_tdata[8]});
					flag_field("irq_line", {7'd0, want.irq}, {7'd0, m_tdata[9]});
					flag_field("map_bank", want.bank, m_tdata[17:10]);
					flag_field("tdata pad", 8'd0, {2'd0, m_tdata[23:18]});
					flag_field("map_source", {7'd0, want.src}, {7'd0, m_tuser[0]});
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_MIRRORING: begin
						mirror_vert = cfg_data[0];
						load_nametables();
					end
					CFG_CHR_MASK: chr_mask = cfg_data;
					CFG_PRG_MASK: prg_mask = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				apply_bus_item(cmd_t'(s_tuser), s_tdata[15:0], s_tdata[23:16], s_tdata[31:24],
					next_due);
				due_results.push_back(next_due);
			end
			pending <= due_results.size();
		end
	end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import cbirp_pkg::*;

	localparam int ITEM_TARGET = 1250;
	localparam int PHASES      = 6;      // config settings in the random part
	localparam int HOLD_AFTER  = 400;    // items sent before the long output stall
	localparam int LONG_HOLD   = 160;    // cycles the receiver holds off
	localparam int DRAIN_LIMIT = 2000;

	// command codes beyond the defined set; the block must answer them inertly
	localparam logic [2:0] CMD_UNDEF_LO = 3'd5;
	localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

	typedef enum int {RX_STEADY, RX_MOSTLY, RX_CADENCE, RX_COIN} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data = '0;

	int mismatches;
	int pending;
	int results_checked;
	int irq_raises;

	int items_sent = 0;
	int reg_writes = 0;
	int burst_left = 0;

	// receiver pacing state
	rx_mode_t rx_mode = RX_STEADY;
	int       rx_left = 0;
	int       hold_left = 0;
	bit       long_hold_done = 1'b0;
	bit [1:0] rx_phase = '0;

	cartridge_bank_irq_ram_port uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	mapper_result_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.pending        (pending),
		.results_checked(results_checked),
		.irq_raises     (irq_raises)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result side. Switches among a few stall patterns every so often; once,
	// after enough items have gone in, it holds off for a long stretch so the
	// block backs up and has to drop s_tready.
	always @(posedge clk) begin
		if (!long_hold_done && items_sent >= HOLD_AFTER) begin
			long_hold_done <= 1'b1;
			hold_left <= LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				rx_left <= $urandom_range(20, 200);
			end else begin
				rx_left <= rx_left - 1;
			end
			rx_phase <= rx_phase + 2'd1;
			case (rx_mode)
				RX_STEADY:  m_tready <= 1'b1;
				RX_MOSTLY:  m_tready <= ($urandom_range(0, 3) != 0);
				RX_CADENCE: m_tready <= (rx_phase != 2'b11);
				default:    m_tready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	// Offer one item and return at the edge where it is taken. Bursts of
	// random length; at a burst boundary tvalid may drop for a random gap.
	// tvalid stays high between back-to-back items.
	task automatic offer_item(input logic [2:0] cmd, input logic [15:0] a,
			input logic [7:0] d, input logic [7:0] ticks);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {ticks, d, a};
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		items_sent++;
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
	endtask

	// stop sending and let every outstanding result come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mapping(input logic mode, input logic [7:0] chr_m, input logic [7:0] prg_m);
		write_reg(CFG_MIRRORING, {7'd0, mode});
		write_reg(CFG_CHR_MASK, chr_m);
		write_reg(CFG_PRG_MASK, prg_m);
		cfg_valid <= 1'b0;
	endtask

	// random address inside one 2 KB page of the cpu bus
	function automatic logic [15:0] page_addr(input logic [4:0] pg);
		return {pg, 11'($urandom)};
	endfunction

	// Pointer setup, a run of RAM writes, pointer back to the start, then the
	// same number of reads. With auto-increment on, the reads return the run.
	task automatic ram_run();
		int n;
		logic [7:0] ptr;
		n = $urandom_range(1, 8);
		ptr = {1'($urandom_range(0, 3) != 0), 7'($urandom)};
		offer_item(CMD_CPU_WRITE, page_addr(PG_PTR), ptr, 8'($urandom));
		repeat (n) offer_item(CMD_CPU_WRITE, page_addr(PG_RAM_DATA), 8'($urandom), 8'($urandom));
		offer_item(CMD_CPU_WRITE, page_addr(PG_PTR), ptr, 8'($urandom));
		repeat (n) offer_item(CMD_CPU_READ, page_addr(PG_RAM_DATA), 8'($urandom), 8'($urandom));
	endtask

	// Load the counter near the top, mostly enabled, tick it, peek at it.
	// Often runs into saturation and the interrupt.
	task automatic irq_run();
		logic [6:0] hi;
		case ($urandom_range(0, 3))
			0: hi = 7'h7F;
			1: hi = 7'h7E;
			2: hi = 7'($urandom_range(8'h78, 8'h7F));
			default: hi = 7'($urandom);
		endcase
		offer_item(CMD_CPU_WRITE, page_addr(PG_IRQ_LO), 8'($urandom), 8'($urandom));
		offer_item(CMD_CPU_WRITE, page_addr(PG_IRQ_HI), {1'($urandom_range(0, 4) != 0), hi},
			8'($urandom));
		repeat ($urandom_range(1, 12)) begin
			offer_item(CMD_TICK, 16'($urandom), 8'($urandom), 8'($urandom));
			if ($urandom_range(0, 4) == 0)
				offer_item(CMD_CPU_READ, page_addr(PG_IRQ_LO), 8'($urandom), 8'($urandom));
		end
		offer_item(CMD_CPU_READ, page_addr(PG_IRQ_LO), 8'($urandom), 8'($urandom));
		offer_item(CMD_CPU_READ, page_addr(PG_IRQ_HI), 8'($urandom), 8'($urandom));
	endtask

	// Program some banks (half of the values in the E0..FF ram range), then
	// look addresses up through them.
	task automatic bank_run();
		logic [4:0] pg;
		logic [7:0] v;
		repeat ($urandom_range(1, 6)) begin
			case ($urandom_range(0, 2))
				0: pg = PG_CHR_LO + 5'($urandom_range(0, 7));
				1: pg = PG_NT_LO + 5'($urandom_range(0, 3));
				default: pg = PG_PRG0 + 5'($urandom_range(0, 2));
			endcase
			v = $urandom_range(0, 1) ? (CIRAM_BASE | 8'($urandom_range(0, 31))) : 8'($urandom);
			offer_item(CMD_CPU_WRITE, page_addr(pg), v, 8'($urandom));
		end
		repeat ($urandom_range(2, 10)) begin
			if ($urandom_range(0, 2) != 0)
				offer_item(CMD_PPU_LOOKUP, 16'($urandom), 8'($urandom), 8'($urandom));
			else if ($urandom_range(0, 3) == 0)
				offer_item(CMD_CPU_LOOKUP, 16'($urandom), 8'($urandom), 8'($urandom));
			else
				offer_item(CMD_CPU_LOOKUP, {1'b1, 15'($urandom)}, 8'($urandom), 8'($urandom));
		end
	endtask

	// anything at all, undefined commands now and then
	task automatic noise_item();
		logic [2:0] cmd;
		if ($urandom_range(0, 15) == 0)
			cmd = 3'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
		else
			cmd = 3'($urandom_range(CMD_CPU_WRITE, CMD_CPU_LOOKUP));
		offer_item(cmd, 16'($urandom), 8'($urandom), 8'($urandom));
	endtask

	initial begin
		int phase_end;
		int drain;
		logic mode;
		logic [7:0] chr_m;
		logic [7:0] prg_m;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// --- directed part, reset configuration ---
		offer_item(CMD_CPU_READ, 16'h4800, 8'h00, 8'h00);     // never-written RAM, no increment
		offer_item(CMD_CPU_LOOKUP, 16'hFFFF, 8'h00, 8'h00);   // fixed last bank
		offer_item(CMD_CPU_LOOKUP, 16'h8000, 8'h00, 8'h00);
		offer_item(CMD_PPU_LOOKUP, 16'h2000, 8'h00, 8'h00);   // reset nametables -> ram
		offer_item(CMD_PPU_LOOKUP, 16'h2C00, 8'h00, 8'h00);
		offer_item(CMD_CPU_WRITE, 16'hFFFF, 8'hFF, 8'hFF);    // pointer 0x7F, increment on
		offer_item(CMD_CPU_WRITE, 16'h4800, 8'hA5, 8'h00);    // pointer wraps to 0x80
		offer_item(CMD_CPU_WRITE, 16'hF800, 8'h7F, 8'h00);    // increment off
		offer_item(CMD_CPU_READ, 16'h4FFF, 8'h00, 8'h00);     // 0xA5 back
		offer_item(CMD_CPU_WRITE, 16'h8000, 8'hFF, 8'h00);
		offer_item(CMD_PPU_LOOKUP, 16'h0000, 8'h00, 8'h00);   // ram disabled -> rom FF
		offer_item(CMD_CPU_WRITE, 16'hE800, 8'h00, 8'h00);    // enable chr ram both halves
		offer_item(CMD_PPU_LOOKUP, 16'h4000, 8'h00, 8'h00);   // wraps to 0, ram bank 7
		offer_item(CMD_CPU_WRITE, 16'hBFFF, 8'hE3, 8'h00);
		offer_item(CMD_PPU_LOOKUP, 16'h1C00, 8'h00, 8'h00);   // ram bank 3
		offer_item(CMD_CPU_WRITE, 16'h5000, 8'hFF, 8'h00);
		offer_item(CMD_CPU_WRITE, 16'h5800, 8'hFF, 8'h00);    // 0x7FFF, enabled
		offer_item(CMD_TICK, 16'h0000, 8'h00, 8'h00);         // zero ticks still saturates
		offer_item(CMD_CPU_READ, 16'h5000, 8'h00, 8'h00);
		offer_item(CMD_CPU_READ, 16'h5FFF, 8'h00, 8'h00);
		offer_item(CMD_TICK, 16'hFFFF, 8'hFF, 8'hFF);         // disabled, no change
		offer_item(CMD_CPU_WRITE, 16'h5000, 8'h00, 8'h00);    // drops the interrupt
		offer_item(CMD_UNDEF_HI, 16'hFFFF, 8'hFF, 8'hFF);
		offer_item(CMD_CPU_WRITE, 16'h0000, 8'h5A, 8'h00);    // unmapped write
		offer_item(CMD_CPU_READ, 16'h6000, 8'h00, 8'h00);     // not claimed
		offer_item(CMD_CPU_LOOKUP, 16'hDFFF, 8'h00, 8'h00);

		// --- random part, one config setting per phase ---
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			case (ph)
				0: {mode, chr_m, prg_m} = {1'b1, 8'hFF, 8'hFF};
				1: {mode, chr_m, prg_m} = {1'b0, 8'h00, 8'h00};
				2: {mode, chr_m, prg_m} = {1'b1, 8'h0F, 8'h3F};
				3: {mode, chr_m, prg_m} = {1'b0, 8'($urandom), 8'($urandom)};
				4: {mode, chr_m, prg_m} = {1'b1, 8'($urandom), 8'($urandom)};
				default: {mode, chr_m, prg_m} = {1'b0, 8'hFF, 8'h80};
			endcase
			set_mapping(mode, chr_m, prg_m);
			phase_end = items_sent + ITEM_TARGET / PHASES;
			while (items_sent < phase_end) begin
				case ($urandom_range(0, 9))
					0, 1, 2: ram_run();
					3, 4, 5: irq_run();
					6, 7:    bank_run();
					default: noise_item();
				endcase
			end
		end

		// drain, bounded, then a few quiet cycles to catch stray results
		s_tvalid <= 1'b0;
		drain = 0;
		do begin
			@(posedge clk);
			drain++;
		end while (pending != 0 && drain < DRAIN_LIMIT);
		repeat (8) @(posedge clk);
		if (pending != 0)
			$display("%0t: %0d expected results never arrived", $time, pending);

		$display("Covered %0d items in %0d config settings (%0d register writes), %0d results checked.",
			items_sent, PHASES + 1, reg_writes, results_checked);
		$display("Interrupt raised %0d times; output held off once for %0d cycles.",
			irq_raises, LONG_HOLD);
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// hang guard
	initial begin
		#2_000_000;
		$display("Timeout at %0t, %0d items sent, %0d results outstanding",
			$time, items_sent, pending);
		$display("Mismatches found");
		$finish;
	end

endmodule
